### hdl/asm_pkg.sv
// ----------------------------------------------------------------------------
// asm_pkg
// shared types, constants and helper functions of the angular separation match
// ----------------------------------------------------------------------------
`default_nettype none

package asm_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 24;
    localparam int CORDIC_STAGES_DEF   = 32;

    localparam int COORD_W     = 34;
    localparam int RADIUS_W    = 33;
    localparam int SEP_W       = 32;
    localparam int IN_TDATA_W  = 136;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 33;
    localparam int LANES       = 4;

    localparam int CW      = 32;
    localparam int VW      = 36;
    localparam int ZW      = 37;
    localparam int ANG_W   = 35;
    localparam int K_W     = 31;
    localparam int WIDE_W  = 68;
    localparam int SQ_W    = 64;
    localparam int SQRT_STEPS = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LON_UNIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT_UNIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAD_UNIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS   = 3'd3;

    localparam logic [ANG_W-1:0] HALF_PI_Q32       = 35'd6746518852;
    localparam logic [ANG_W-1:0] PI_Q32            = 35'd13493037705;
    localparam logic [ANG_W-1:0] THREE_HALF_PI_Q32 = 35'd20239556557;
    localparam logic [ANG_W-1:0] TWO_PI_Q32        = 35'd26986075409;
    localparam logic [SEP_W-1:0] PI_Q30            = 32'd3373259426;
    localparam logic [K_W-1:0]   K_HOUR_Q31        = 31'd562209904;
    localparam logic [K_W-1:0]   K_DEG_Q36         = 31'd1199381129;
    localparam logic signed [CW-1:0] GAIN_Q30      = 32'sd652032874;
    localparam logic [SQ_W-1:0]  ONE_Q60           = 64'h1000_0000_0000_0000;
    localparam logic signed [2*CW-1:0] Q30_HALF    = 64'sd536870912;
    localparam logic [CW-1:0]    DIFF_CLAMP        = 32'h8000_0000;

    typedef enum logic [1:0] {
        UNIT_HOURS   = 2'd0,
        UNIT_DEGREES = 2'd1,
        UNIT_RADIANS = 2'd2
    } unit_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } rot_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [SQ_W-1:0] n;
        logic [SQ_W-1:0] res;
    } sqrt_t;

    function automatic int rad_width(input int frac_bits);
        int w;
        w = 66 - frac_bits;
        if (w < 35)
        begin
            w = 35;
        end
        return w;
    endfunction

    // atan(2^-i) in q32, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_q32(input int i);
        logic [ANG_W-1:0] v;
        case (i)
            0:  v = 35'd3373259426;
            1:  v = 35'd1991351318;
            2:  v = 35'd1052175346;
            3:  v = 35'd534100635;
            4:  v = 35'd268086748;
            5:  v = 35'd134174063;
            6:  v = 35'd67103403;
            7:  v = 35'd33553749;
            8:  v = 35'd16777131;
            9:  v = 35'd8388597;
            10: v = 35'd4194303;
            default:
            begin
                if (i <= 32)
                begin
                    v = ANG_W'(1) << (32 - i);
                end
                else if (i == 33)
                begin
                    v = ANG_W'(1);
                end
                else
                begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

    // magnitude with frac_bits fraction bits to q32 radians
    function automatic logic [WIDE_W-1:0] mag_to_rad(input logic [COORD_W-1:0] mag,
                                                     input unit_t unit,
                                                     input int frac_bits);
        logic [COORD_W+K_W-1:0] prod;
        logic [WIDE_W-1:0]      wide;
        logic [WIDE_W-1:0]      one;
        int                     sh;
        one  = WIDE_W'(1);
        prod = '0;
        sh   = 1;
        case (unit)
            UNIT_HOURS:
            begin
                prod = mag * K_HOUR_Q31;
                sh   = frac_bits + 31 - 32;
            end
            UNIT_DEGREES:
            begin
                prod = mag * K_DEG_Q36;
                sh   = frac_bits + 36 - 32;
            end
            default:
            begin
                prod = '0;
            end
        endcase
        if (unit == UNIT_HOURS || unit == UNIT_DEGREES)
        begin
            wide = (WIDE_W'(prod) + (one << (sh - 1))) >> sh;
        end
        else if (frac_bits <= 32)
        begin
            wide = WIDE_W'(mag) << (32 - frac_bits);
        end
        else
        begin
            wide = (WIDE_W'(mag) + (one << (frac_bits - 33))) >> (frac_bits - 32);
        end
        return wide;
    endfunction

    function automatic logic signed [CW:0] mul_q30(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        logic signed [2*CW-1:0] q;
        p = a * b;
        q = (p + Q30_HALF) >>> 30;
        return q[CW:0];
    endfunction

endpackage

`default_nettype wire

### hdl/angular_separation_match.sv
// ----------------------------------------------------------------------------
// angular_separation_match
// great-circle separation of a key and a candidate position with cone test
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// s_*       in         s_tvalid / s_tready       key_lon, key_lat, cand_lon, cand_lat
// m_*       out        m_tvalid / m_tready       separation, within_radius
// cfg_*     in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one transaction per clock in and out while m_* does not stall; fully pipelined cordic and root cells
// path from input to m_tvalid: unit conversion with its modulo steps, the rotation cordic chain,
// the chord and square registers, the root chain, the vectoring chain, the separation and output registers
// a held result on m_* stalls the whole chain only when its last stage is full
// reset clears the valid chain, the output valid flag, the radius and the unit registers
// ----------------------------------------------------------------------------
`default_nettype none

module angular_separation_match #(
    parameter int ANGLE_FRAC_BITS = asm_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = asm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // key_lon, key_lat, cand_lon, cand_lat
    input  logic [asm_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // separation, within_radius, zero fill
    output logic [asm_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [asm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [asm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int RAD_W     = asm_pkg::rad_width(ANGLE_FRAC_BITS);
    localparam int MOD_STEPS = RAD_W - 34;
    localparam int CONV_LAT  = MOD_STEPS + 3;
    localparam int LAT       = CONV_LAT + 2 * CORDIC_STAGES + 4 + asm_pkg::SQRT_STEPS + 1;
    localparam int CW        = asm_pkg::CW;
    localparam int LANES     = asm_pkg::LANES;

    logic                          adv;
    logic [LAT-1:0]                vld_reg;
    asm_pkg::unit_t                lon_unit_reg;
    asm_pkg::unit_t                lat_unit_reg;
    asm_pkg::unit_t                rad_unit_reg;
    logic [asm_pkg::RADIUS_W-1:0]  radius_reg;
    logic [RAD_W-1:0]              rad_reg;

    asm_pkg::rot_t                 rot_q [LANES][CORDIC_STAGES+1];
    logic signed [CW-1:0]          cos_v [LANES];
    logic signed [CW-1:0]          sin_v [LANES];
    logic signed [CW:0]            pv_next [2][3];
    logic signed [CW:0]            pv_reg  [2][3];
    logic signed [CW+1:0]          dif [3];
    logic [CW+1:0]                 dabs [3];
    logic [CW-1:0]                 dmag_next [3];
    logic [CW-1:0]                 dmag_reg  [3];
    logic [asm_pkg::SQ_W-1:0]      sq_reg [3];
    logic [asm_pkg::SQ_W+1:0]      sum;
    logic [asm_pkg::SQ_W-1:0]      s60;
    asm_pkg::sqrt_t                ss_q [asm_pkg::SQRT_STEPS+1];
    asm_pkg::sqrt_t                cc_q [asm_pkg::SQRT_STEPS+1];
    asm_pkg::vec_t                 vec_q [CORDIC_STAGES+1];
    logic [asm_pkg::ANG_W-1:0]     zc;
    logic [asm_pkg::ANG_W:0]       zr;
    logic [asm_pkg::SEP_W-1:0]     sep_next;
    logic [asm_pkg::SEP_W-1:0]     sep_reg;
    logic                          within_reg;
    logic                          m_tvalid_reg;
    logic [asm_pkg::SEP_W-1:0]     m_sep_reg;
    logic                          m_within_reg;

    assign adv       = !m_tvalid_reg || m_tready || !vld_reg[LAT-1];
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_unit_reg <= asm_pkg::UNIT_HOURS;
            lat_unit_reg <= asm_pkg::UNIT_DEGREES;
            rad_unit_reg <= asm_pkg::UNIT_DEGREES;
            radius_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                asm_pkg::CFG_LON_UNIT: lon_unit_reg <= asm_pkg::unit_t'(cfg_data[1:0]);
                asm_pkg::CFG_LAT_UNIT: lat_unit_reg <= asm_pkg::unit_t'(cfg_data[1:0]);
                asm_pkg::CFG_RAD_UNIT: rad_unit_reg <= asm_pkg::unit_t'(cfg_data[1:0]);
                asm_pkg::CFG_RADIUS:   radius_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg <= RAD_W'(asm_pkg::mag_to_rad({1'b0, radius_reg}, rad_unit_reg,
                                              ANGLE_FRAC_BITS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // coordinate lanes: key_lon, key_lat, cand_lon, cand_lat
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        asm_angle_conv #(
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_conv (
            .clk   (clk),
            .adv   (adv),
            .coord (s_tdata[l*asm_pkg::COORD_W +: asm_pkg::COORD_W]),
            .unit  ((l % 2 == 0) ? lon_unit_reg : lat_unit_reg),
            .seed  (rot_q[l][0])
        );
        for (genvar i = 0; i < CORDIC_STAGES; i++)
        begin : g_rot
            asm_rot_cell #(
                .IDX (i)
            ) u_rot (
                .clk   (clk),
                .adv   (adv),
                .d_in  (rot_q[l][i]),
                .d_out (rot_q[l][i+1])
            );
        end
        assign cos_v[l] = rot_q[l][CORDIC_STAGES].flip ? -rot_q[l][CORDIC_STAGES].x
                                                       :  rot_q[l][CORDIC_STAGES].x;
        assign sin_v[l] = rot_q[l][CORDIC_STAGES].flip ? -rot_q[l][CORDIC_STAGES].y
                                                       :  rot_q[l][CORDIC_STAGES].y;
    end

    always_comb
    begin
        for (int p = 0; p < 2; p++)
        begin
            pv_next[p][0] = asm_pkg::mul_q30(cos_v[2*p], cos_v[2*p+1]);
            pv_next[p][1] = asm_pkg::mul_q30(sin_v[2*p], cos_v[2*p+1]);
            pv_next[p][2] = (CW+1)'(sin_v[2*p+1]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dif[i]  = (CW+2)'(pv_reg[0][i]) - (CW+2)'(pv_reg[1][i]);
            dabs[i] = (dif[i] < 0) ? unsigned'(-dif[i]) : unsigned'(dif[i]);
            dmag_next[i] = (dabs[i] > (CW+2)'(asm_pkg::DIFF_CLAMP)) ? asm_pkg::DIFF_CLAMP
                                                                    : dabs[i][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pv_reg   <= pv_next;
            dmag_reg <= dmag_next;
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= dmag_reg[i] * dmag_reg[i];
            end
        end
    end

    assign sum = (asm_pkg::SQ_W+2)'(sq_reg[0]) + (asm_pkg::SQ_W+2)'(sq_reg[1])
               + (asm_pkg::SQ_W+2)'(sq_reg[2]);
    assign s60 = sum[asm_pkg::SQ_W+1:2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss_q[0].n   <= s60;
            ss_q[0].res <= '0;
            cc_q[0].n   <= (s60 < asm_pkg::ONE_Q60) ? (asm_pkg::ONE_Q60 - s60) : '0;
            cc_q[0].res <= '0;
        end
    end

    for (genvar j = 0; j < asm_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        asm_sqrt_cell #(
            .BIT_POS (62 - 2 * j)
        ) u_ss (
            .clk   (clk),
            .adv   (adv),
            .d_in  (ss_q[j]),
            .d_out (ss_q[j+1])
        );
        asm_sqrt_cell #(
            .BIT_POS (62 - 2 * j)
        ) u_cc (
            .clk   (clk),
            .adv   (adv),
            .d_in  (cc_q[j]),
            .d_out (cc_q[j+1])
        );
    end

    assign vec_q[0].x = signed'(asm_pkg::VW'(cc_q[asm_pkg::SQRT_STEPS].res[31:0]));
    assign vec_q[0].y = signed'(asm_pkg::VW'(ss_q[asm_pkg::SQRT_STEPS].res[31:0]));
    assign vec_q[0].z = '0;

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_vec
        asm_vec_cell #(
            .IDX (i)
        ) u_vec (
            .clk   (clk),
            .adv   (adv),
            .d_in  (vec_q[i]),
            .d_out (vec_q[i+1])
        );
    end

    always_comb
    begin
        if (vec_q[CORDIC_STAGES].z < 0)
        begin
            zc = '0;
        end
        else if (vec_q[CORDIC_STAGES].z > signed'(asm_pkg::ZW'(asm_pkg::HALF_PI_Q32)))
        begin
            zc = asm_pkg::HALF_PI_Q32;
        end
        else
        begin
            zc = vec_q[CORDIC_STAGES].z[asm_pkg::ANG_W-1:0];
        end
        zr       = ((asm_pkg::ANG_W+1)'(zc) + 1'b1) >> 1;
        sep_next = zr[asm_pkg::SEP_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sep_reg    <= sep_next;
            within_reg <= RAD_W'({sep_next, 2'b00}) <= rad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv && vld_reg[LAT-1])
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[LAT-1])
        begin
            m_sep_reg    <= sep_reg;
            m_within_reg <= within_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(asm_pkg::OUT_TDATA_W - asm_pkg::SEP_W - 1){1'b0}},
                       m_within_reg, m_sep_reg};

endmodule

`default_nettype wire

### hdl/asm_angle_conv.sv
// ----------------------------------------------------------------------------
// asm_angle_conv
// unit conversion, wrap into one turn and quadrant fold of one coordinate
// ----------------------------------------------------------------------------
`default_nettype none

module asm_angle_conv #(
    parameter int ANGLE_FRAC_BITS = asm_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        adv,
    input  logic [asm_pkg::COORD_W-1:0] coord,
    input  asm_pkg::unit_t              unit,
    output asm_pkg::rot_t               seed
);

    localparam int RAD_W     = asm_pkg::rad_width(ANGLE_FRAC_BITS);
    localparam int MOD_STEPS = RAD_W - 34;

    logic [asm_pkg::COORD_W-1:0] mag;
    logic [RAD_W-1:0]            mod_reg [MOD_STEPS+1];
    logic                        neg_reg [MOD_STEPS+1];
    logic [asm_pkg::ANG_W-1:0]   rem;
    logic [asm_pkg::ANG_W-1:0]   wrap_next;
    logic [asm_pkg::ANG_W-1:0]   wrap_reg;
    asm_pkg::rot_t               seed_next;
    asm_pkg::rot_t               seed_reg;

    assign mag = coord[asm_pkg::COORD_W-1] ? (~coord + 1'b1) : coord;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mod_reg[0] <= RAD_W'(asm_pkg::mag_to_rad(mag, unit, ANGLE_FRAC_BITS));
            neg_reg[0] <= coord[asm_pkg::COORD_W-1];
        end
    end

    // one restoring step per stage, largest multiple of a full turn first
    for (genvar j = 0; j < MOD_STEPS; j++)
    begin : g_mod
        localparam logic [RAD_W-1:0] MODV =
            RAD_W'(asm_pkg::TWO_PI_Q32) << (MOD_STEPS - 1 - j);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                mod_reg[j+1] <= (mod_reg[j] >= MODV) ? (mod_reg[j] - MODV) : mod_reg[j];
                neg_reg[j+1] <= neg_reg[j];
            end
        end
    end

    assign rem = mod_reg[MOD_STEPS][asm_pkg::ANG_W-1:0];

    always_comb
    begin
        if (neg_reg[MOD_STEPS] && (rem != '0))
        begin
            wrap_next = asm_pkg::TWO_PI_Q32 - rem;
        end
        else
        begin
            wrap_next = rem;
        end
    end

    always_comb
    begin
        seed_next.x    = asm_pkg::GAIN_Q30;
        seed_next.y    = '0;
        seed_next.flip = 1'b0;
        if ((wrap_reg > asm_pkg::HALF_PI_Q32) && (wrap_reg < asm_pkg::THREE_HALF_PI_Q32))
        begin
            seed_next.z    = signed'(asm_pkg::ZW'(wrap_reg))
                           - signed'(asm_pkg::ZW'(asm_pkg::PI_Q32));
            seed_next.flip = 1'b1;
        end
        else if (wrap_reg >= asm_pkg::THREE_HALF_PI_Q32)
        begin
            seed_next.z = signed'(asm_pkg::ZW'(wrap_reg))
                        - signed'(asm_pkg::ZW'(asm_pkg::TWO_PI_Q32));
        end
        else
        begin
            seed_next.z = signed'(asm_pkg::ZW'(wrap_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wrap_reg <= wrap_next;
            seed_reg <= seed_next;
        end
    end

    assign seed = seed_reg;

endmodule

`default_nettype wire

### hdl/asm_rot_cell.sv
// ----------------------------------------------------------------------------
// asm_rot_cell
// one rotation-mode cordic iteration, registered
// ----------------------------------------------------------------------------
`default_nettype none

module asm_rot_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          adv,
    input  asm_pkg::rot_t d_in,
    output asm_pkg::rot_t d_out
);

    localparam logic signed [asm_pkg::ZW-1:0] ATAN =
        signed'(asm_pkg::ZW'(asm_pkg::atan_q32(IDX)));

    logic signed [asm_pkg::CW-1:0] dx;
    logic signed [asm_pkg::CW-1:0] dy;
    asm_pkg::rot_t                 rot_next;
    asm_pkg::rot_t                 rot_reg;

    assign dx = d_in.y >>> IDX;
    assign dy = d_in.x >>> IDX;

    always_comb
    begin
        rot_next.flip = d_in.flip;
        if (d_in.z >= 0)
        begin
            rot_next.x = d_in.x - dx;
            rot_next.y = d_in.y + dy;
            rot_next.z = d_in.z - ATAN;
        end
        else
        begin
            rot_next.x = d_in.x + dx;
            rot_next.y = d_in.y - dy;
            rot_next.z = d_in.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rot_reg <= rot_next;
        end
    end

    assign d_out = rot_reg;

endmodule

`default_nettype wire

### hdl/asm_sqrt_cell.sv
// ----------------------------------------------------------------------------
// asm_sqrt_cell
// one result bit of the integer square root, registered
// ----------------------------------------------------------------------------
`default_nettype none

module asm_sqrt_cell #(
    parameter int BIT_POS = 62
) (
    input  logic           clk,
    input  logic           adv,
    input  asm_pkg::sqrt_t d_in,
    output asm_pkg::sqrt_t d_out
);

    localparam logic [asm_pkg::SQ_W-1:0] BITV = asm_pkg::SQ_W'(1) << BIT_POS;

    logic [asm_pkg::SQ_W-1:0] trial;
    asm_pkg::sqrt_t           sq_next;
    asm_pkg::sqrt_t           sq_reg;

    assign trial = d_in.res + BITV;

    always_comb
    begin
        if (d_in.n >= trial)
        begin
            sq_next.n   = d_in.n - trial;
            sq_next.res = (d_in.res >> 1) + BITV;
        end
        else
        begin
            sq_next.n   = d_in.n;
            sq_next.res = d_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg <= sq_next;
        end
    end

    assign d_out = sq_reg;

endmodule

`default_nettype wire

### hdl/asm_vec_cell.sv
// ----------------------------------------------------------------------------
// asm_vec_cell
// one vectoring-mode cordic iteration, registered
// ----------------------------------------------------------------------------
`default_nettype none

module asm_vec_cell #(
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic          adv,
    input  asm_pkg::vec_t d_in,
    output asm_pkg::vec_t d_out
);

    localparam logic signed [asm_pkg::ZW-1:0] ATAN =
        signed'(asm_pkg::ZW'(asm_pkg::atan_q32(IDX)));

    logic signed [asm_pkg::VW-1:0] dx;
    logic signed [asm_pkg::VW-1:0] dy;
    asm_pkg::vec_t                 vec_next;
    asm_pkg::vec_t                 vec_reg;

    assign dx = d_in.y >>> IDX;
    assign dy = d_in.x >>> IDX;

    always_comb
    begin
        if (d_in.y > 0)
        begin
            vec_next.x = d_in.x + dx;
            vec_next.y = d_in.y - dy;
            vec_next.z = d_in.z + ATAN;
        end
        else
        begin
            vec_next.x = d_in.x - dx;
            vec_next.y = d_in.y + dy;
            vec_next.z = d_in.z - ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vec_reg <= vec_next;
        end
    end

    assign d_out = vec_reg;

endmodule

`default_nettype wire

### hdl/asm_checker.sv
// ----------------------------------------------------------------------------
// asm_checker
// port-level checks of the angular separation match, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module asm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [asm_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // held transaction keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transaction changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[asm_pkg::SEP_W-1:0] <= asm_pkg::PI_Q30)
        else $error("separation beyond pi");

    a_zero_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[asm_pkg::SEP_W-1:0] == '0) |-> m_tdata[asm_pkg::SEP_W])
        else $error("zero separation not flagged as match");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind angular_separation_match asm_checker u_asm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the angular separation cone match: a bit-exact
// fixed-point predictor of the unit conversion, cordic sine/cosine, chord,
// root and atan2 chain works out each result, which is checked in order
// against the output stream under random idling and stalls on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    typedef logic [63:0] u64;
    typedef logic signed [asm_pkg::COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [asm_pkg::SEP_W-1:0] sep;
        logic                      in_cone;
    } match_t;

    typedef struct {
        coord_t key_lon;
        coord_t key_lat;
        coord_t cand_lon;
        coord_t cand_lat;
    } pair_row_t;

    localparam int           STAGES         = 32;
    localparam int           DRAIN_CYCLES   = 160;
    localparam longint       CYCLE_LIMIT    = 1000000;
    localparam logic [1:0]   UNIT_RESERVED  = 2'd3;
    localparam logic [asm_pkg::CFG_DATA_W-1:0] RADIUS_MAX = '1;
    localparam int           PHASES         = 7;
    localparam int           PHASE_ITEMS    = 245;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [asm_pkg::IN_TDATA_W-1:0]   s_tdata;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [asm_pkg::OUT_TDATA_W-1:0]  m_tdata;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [asm_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [asm_pkg::CFG_DATA_W-1:0]   cfg_data;

    // predictor copy of the unit and radius registers
    logic [1:0]                       lon_unit_r;
    logic [1:0]                       lat_unit_r;
    logic [1:0]                       rad_unit_r;
    logic [asm_pkg::RADIUS_W-1:0]     radius_r;

    longint                  arctan[STAGES];
    u64                      pi62;
    longint                  half_pi;
    longint                  pi32;
    longint                  two_pi;
    u64                      k_hour;
    u64                      k_deg;

    match_t                  pending_matches[$];
    int                      mismatches;
    int                      pairs_sent;
    int                      matches_seen = 0;
    int                      within_hits = 0;
    longint                  cycles = 0;
    bit                      no_idle;

    angular_separation_match u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // key_lon, key_lat, cand_lon, cand_lat
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // separation, within_radius, zero fill
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // arctan of 1/n in q62 by series
    function automatic u64 arctan_inv(input u64 n);
        u64 p;
        u64 acc;
        u64 k;
        p   = (u64'(1) << 62) / n;
        acc = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0] == 1'b0)
            begin
                acc = acc + p / (2 * k + 1);
            end
            else
            begin
                acc = acc - p / (2 * k + 1);
            end
            p = p / (n * n);
            k = k + 1;
        end
        return acc;
    endfunction

    function automatic longint arctan_pow2(input int i);
        u64 p;
        u64 acc;
        u64 k;
        p   = u64'(1) << (62 - i);
        acc = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0] == 1'b0)
            begin
                acc = acc + p / (2 * k + 1);
            end
            else
            begin
                acc = acc - p / (2 * k + 1);
            end
            p = (2 * i < 64) ? (p >> (2 * i)) : 0;
            k = k + 1;
        end
        return longint'((acc + (u64'(1) << 29)) >> 30);
    endfunction

    task automatic setup_constants();
        pi62    = 16 * arctan_inv(5) - 4 * arctan_inv(239);
        half_pi = longint'((pi62 + (u64'(1) << 30)) >> 31);
        pi32    = longint'((pi62 + (u64'(1) << 29)) >> 30);
        two_pi  = longint'((pi62 + (u64'(1) << 28)) >> 29);
        k_hour  = ((pi62 / 12) + (u64'(1) << 30)) >> 31;
        k_deg   = ((pi62 / 180) + (u64'(1) << 25)) >> 26;
        arctan[0] = longint'((pi62 + (u64'(1) << 31)) >> 32);
        for (int i = 1; i < STAGES; i++)
        begin
            arctan[i] = arctan_pow2(i);
        end
    endtask

    function automatic u64 to_radians(input u64 mag, input logic [1:0] unit);
        u64 r;
        case (unit)
            asm_pkg::UNIT_HOURS:   r = (mag * k_hour + (u64'(1) << 22)) >> 23;
            asm_pkg::UNIT_DEGREES: r = (mag * k_deg + (u64'(1) << 27)) >> 28;
            default:               r = mag << 8;
        endcase
        return r;
    endfunction

    function automatic longint wrapped_angle(input coord_t raw, input logic [1:0] unit);
        u64 mag;
        u64 r;
        mag = raw[asm_pkg::COORD_W-1] ? u64'(-raw) & ((u64'(1) << asm_pkg::COORD_W) - 1)
                                      : u64'(raw);
        r   = to_radians(mag, unit) % u64'(two_pi);
        if (raw[asm_pkg::COORD_W-1] && r != 0)
        begin
            r = u64'(two_pi) - r;
        end
        return longint'(r);
    endfunction

    function automatic void sin_cos(input longint a, output longint c, output longint s);
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = 1'b0;
        x    = longint'(asm_pkg::GAIN_Q30);
        y    = 0;
        if (a > half_pi && a < pi32 + half_pi)
        begin
            a    = a - pi32;
            flip = 1'b1;
        end
        else if (a >= pi32 + half_pi)
        begin
            a = a - two_pi;
        end
        z = a;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan[i];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint round_q30(input longint a, input longint b);
        return (a * b + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic u64 floor_root(input u64 n);
        u64 res;
        u64 probe;
        res   = 0;
        probe = u64'(1) << 62;
        while (probe > n)
        begin
            probe = probe >> 2;
        end
        while (probe != 0)
        begin
            if (n >= res + probe)
            begin
                n   = n - (res + probe);
                res = (res >> 1) + probe;
            end
            else
            begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    function automatic void position_vector(input longint lon, input longint lat,
                                            output longint v[3]);
        longint cl;
        longint sl;
        longint cb;
        longint sb;
        sin_cos(lon, cl, sl);
        sin_cos(lat, cb, sb);
        v[0] = round_q30(cl, cb);
        v[1] = round_q30(sl, cb);
        v[2] = sb;
    endfunction

    function automatic match_t separation_of(input pair_row_t p);
        longint v1[3];
        longint v2[3];
        longint d;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        u64     acc;
        u64     s60;
        u64     c60;
        u64     sep;
        u64     rad;
        match_t m;
        position_vector(wrapped_angle(p.key_lon, lon_unit_r),
                        wrapped_angle(p.key_lat, lat_unit_r), v1);
        position_vector(wrapped_angle(p.cand_lon, lon_unit_r),
                        wrapped_angle(p.cand_lat, lat_unit_r), v2);
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = v1[i] - v2[i];
            if (d < 0)
            begin
                d = -d;
            end
            if (d > (longint'(1) << 31))
            begin
                d = longint'(1) << 31;
            end
            acc = acc + u64'(d) * u64'(d);
        end
        s60 = acc >> 2;
        c60 = (s60 < (u64'(1) << 60)) ? (u64'(1) << 60) - s60 : 0;
        x = longint'(floor_root(c60));
        y = longint'(floor_root(s60));
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan[i];
            end
        end
        if (z < 0)
        begin
            z = 0;
        end
        if (z > half_pi)
        begin
            z = half_pi;
        end
        sep       = (u64'(z) + 1) >> 1;
        rad       = to_radians(u64'(radius_r), rad_unit_r);
        m.sep     = sep[asm_pkg::SEP_W-1:0];
        m.in_cone = ((sep << 2) <= rad);
        return m;
    endfunction

    function automatic coord_t deg(input int x);
        return coord_t'(longint'(x) <<< asm_pkg::ANGLE_FRAC_BITS_DEF);
    endfunction

    task automatic idle_gap();
        while (!no_idle && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic write_register(input logic [asm_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [asm_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (idx)
            asm_pkg::CFG_LON_UNIT: lon_unit_r = value[1:0];
            asm_pkg::CFG_LAT_UNIT: lat_unit_r = value[1:0];
            asm_pkg::CFG_RAD_UNIT: rad_unit_r = value[1:0];
            asm_pkg::CFG_RADIUS:   radius_r   = value[asm_pkg::RADIUS_W-1:0];
            default:               ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // pin_cone: cone flag known without the predictor
    task automatic send_pair(input pair_row_t p, input bit pin_cone, input bit cone_hit);
        match_t m;
        @(negedge clk);
        idle_gap();
        s_tvalid <= 1'b1;
        s_tdata  <= {p.cand_lat, p.cand_lon, p.key_lat, p.key_lon};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        m = separation_of(p);
        if (pin_cone)
        begin
            m.in_cone = cone_hit;
        end
        pending_matches.push_back(m);
        pairs_sent++;
    endtask

    task automatic end_of_stream();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic settle();
        wait (pending_matches.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic coord_t random_coord();
        coord_t c;
        case ($urandom_range(0, 3))
            0:       c = coord_t'({$urandom(), $urandom()});
            1:       c = deg($urandom_range(0, 360)) - deg(180);
            2:       c = coord_t'(longint'($urandom_range(0, 32'h7fff_ffff)))
                         - coord_t'(longint'(32'h4000_0000));
            default: c = coord_t'({$urandom(), $urandom()}) >>> $urandom_range(0, 33);
        endcase
        return c;
    endfunction

    function automatic coord_t nudge(input coord_t c);
        int span;
        span = $urandom_range(0, 24);
        return c + coord_t'(longint'($urandom_range(0, 32'hffff_ffff) >> (31 - span)))
                 - coord_t'(longint'(1) << span);
    endfunction

    function automatic logic [asm_pkg::CFG_DATA_W-1:0] random_radius();
        logic [asm_pkg::CFG_DATA_W-1:0] r;
        case ($urandom_range(0, 4))
            0:       r = '0;
            1:       r = RADIUS_MAX;
            2:       r = asm_pkg::CFG_DATA_W'({$urandom(), $urandom()});
            default: r = asm_pkg::CFG_DATA_W'($urandom_range(0, 32'h0400_0000));
        endcase
        return r;
    endfunction

    initial
    begin
        pair_row_t rows[$];
        pair_row_t p;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = asm_pkg::CFG_LON_UNIT;
        cfg_data    = '0;
        lon_unit_r  = asm_pkg::UNIT_HOURS;
        lat_unit_r  = asm_pkg::UNIT_DEGREES;
        rad_unit_r  = asm_pkg::UNIT_DEGREES;
        radius_r    = '0;
        mismatches  = 0;
        pairs_sent  = 0;
        no_idle     = 1'b0;
        setup_constants();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings first, then degrees everywhere with the widest cone
        p = '{deg(10), deg(20), deg(10), deg(20)};
        send_pair(p, 1'b0, 1'b0);
        p = '{deg(3), deg(-40), deg(5), deg(60)};
        send_pair(p, 1'b0, 1'b0);
        end_of_stream();
        settle();
        write_register(asm_pkg::CFG_LON_UNIT, asm_pkg::UNIT_DEGREES);
        write_register(asm_pkg::CFG_LAT_UNIT, asm_pkg::UNIT_DEGREES);
        write_register(asm_pkg::CFG_RAD_UNIT, asm_pkg::UNIT_DEGREES);
        write_register(asm_pkg::CFG_RADIUS, RADIUS_MAX);

        rows.push_back('{deg(0), deg(0), deg(0), deg(0)});
        rows.push_back('{deg(0), deg(0), deg(180), deg(0)});
        rows.push_back('{deg(0), deg(90), deg(0), deg(-90)});
        rows.push_back('{deg(45), deg(90), deg(200), deg(90)});
        rows.push_back('{deg(0), deg(0), deg(90), deg(0)});
        rows.push_back('{deg(359), deg(0), deg(1), deg(0)});
        rows.push_back('{deg(-45), deg(30), deg(315), deg(30)});
        rows.push_back('{deg(10), deg(120), deg(10), deg(60)});
        rows.push_back('{deg(0), deg(0), coord_t'(1), coord_t'(0)});
        rows.push_back('{deg(0), deg(0), deg(180), coord_t'(1)});
        rows.push_back('{deg(720), deg(-450), deg(-720), deg(270)});
        rows.push_back('{coord_t'(34'h1_ffff_ffff), coord_t'(34'h1_ffff_ffff),
                         coord_t'(34'h2_0000_0000), coord_t'(34'h2_0000_0000)});
        rows.push_back('{coord_t'(34'h2_0000_0000), coord_t'(34'h1_ffff_ffff),
                         coord_t'(34'h1_ffff_ffff), coord_t'(34'h2_0000_0000)});
        rows.push_back('{coord_t'(34'h3_ffff_ffff), coord_t'(0),
                         coord_t'(34'h2_aaaa_aaaa), coord_t'(34'h1_5555_5555)});
        foreach (rows[i])
        begin
            send_pair(rows[i], 1'b1, 1'b1);
        end
        end_of_stream();
        settle();

        // radians everywhere, including the unused unit code and ignored indexes
        write_register(asm_pkg::CFG_LON_UNIT, asm_pkg::UNIT_RADIANS);
        write_register(asm_pkg::CFG_LAT_UNIT, UNIT_RESERVED);
        write_register(asm_pkg::CFG_RAD_UNIT, UNIT_RESERVED);
        write_register(asm_pkg::CFG_RADIUS, '0);
        write_register(asm_pkg::CFG_IDX_W'($urandom_range(4, 7)), RADIUS_MAX);
        rows.delete();
        rows.push_back('{coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0)});
        rows.push_back('{coord_t'(longint'(53) <<< 20), coord_t'(0),
                         coord_t'(-(longint'(53) <<< 20)), coord_t'(0)});
        rows.push_back('{coord_t'(34'h1_ffff_ffff), coord_t'(34'h2_0000_0000),
                         coord_t'(0), coord_t'(0)});
        foreach (rows[i])
        begin
            send_pair(rows[i], 1'b0, 1'b0);
        end
        end_of_stream();
        settle();
        write_register(asm_pkg::CFG_LON_UNIT, asm_pkg::UNIT_HOURS);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_register(asm_pkg::CFG_LON_UNIT, 2'($urandom_range(0, 3)));
            write_register(asm_pkg::CFG_LAT_UNIT, 2'($urandom_range(0, 3)));
            write_register(asm_pkg::CFG_RAD_UNIT, 2'($urandom_range(0, 3)));
            write_register(asm_pkg::CFG_RADIUS, random_radius());
            no_idle = (ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                p.key_lon = random_coord();
                p.key_lat = random_coord();
                if ($urandom_range(0, 1) == 0)
                begin
                    p.cand_lon = nudge(p.key_lon);
                    p.cand_lat = nudge(p.key_lat);
                end
                else
                begin
                    p.cand_lon = random_coord();
                    p.cand_lat = random_coord();
                end
                send_pair(p, 1'b0, 1'b0);
            end
            end_of_stream();
            settle();
        end

        $display("%0d pairs sent over %0d unit/radius settings, %0d results checked",
                 pairs_sent, PHASES + 3, matches_seen);
        $display("%0d results inside the cone, %0d mismatches", within_hits, mismatches);
        if (mismatches == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(negedge clk)
    begin
        m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    always @(posedge clk)
    begin
        match_t exp_m;
        if (rst_n && m_tvalid && m_tready)
        begin
            matches_seen++;
            if (m_tdata[asm_pkg::SEP_W])
            begin
                within_hits++;
            end
            if (pending_matches.size() == 0)
            begin
                $error("result transaction with nothing expected: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                exp_m = pending_matches.pop_front();
                if (m_tdata[asm_pkg::SEP_W-1:0] !== exp_m.sep)
                begin
                    $error("separation: expected %0d, got %0d", exp_m.sep,
                           m_tdata[asm_pkg::SEP_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[asm_pkg::SEP_W] !== exp_m.in_cone)
                begin
                    $error("within_radius: expected %0b, got %0b", exp_m.in_cone,
                           m_tdata[asm_pkg::SEP_W]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_matches.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

`default_nettype wire
